// File: hw/rtl/rtss_pkg.sv
// ----------------------------------------------------------------------------
// rtss_pkg
// Shared types and constants of the record table with search and sort.
// ----------------------------------------------------------------------------
package rtss_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int MAX_RUN   = 16;

  localparam logic [15:0] PRICE_LOW_RST  = 16'd100;
  localparam logic [15:0] PRICE_HIGH_RST = 16'd800;

  // Register select bit of paddr: register i lies at byte address 4*i.
  localparam logic REG_PRICE_LOW  = 1'b0;
  localparam logic REG_PRICE_HIGH = 1'b1;

  typedef enum logic [2:0] {
    CMD_APPEND = 3'd0,
    CMD_READ   = 3'd1,
    CMD_SEARCH = 3'd2,
    CMD_SORT   = 3'd3,
    CMD_UPDATE = 3'd4,
    CMD_DELETE = 3'd5,
    CMD_FILTER = 3'd6
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_NOMATCH = 2'd1,
    STAT_FULL    = 2'd2,
    STAT_BADIDX  = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_READ_WAIT,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_EMIT_RD,
    S_EMIT_CHK,
    S_NOMATCH,
    S_SORT_RDI,
    S_SORT_LDI,
    S_SORT_RDJ,
    S_SORT_CMP,
    S_SUMMARY
  } state_e;

  typedef struct packed {
    logic [15:0] id;
    logic [15:0] price;
    logic [63:0] name;
    logic [63:0] category;
  } rec_t;

  typedef struct packed {
    status_e    status;
    logic [3:0] slot;
    rec_t       rec;
    logic [4:0] affected;
    logic       last;
  } result_t;

endpackage

// File: hw/rtl/record_table_sort_search.sv
// ----------------------------------------------------------------------------
// record_table_sort_search
// Table of up to DEPTH records with append, read, search, sort, update,
// delete and price filter commands, run by a sequencer over one RAM.
//
// One command is taken per input transfer when in_valid_i is high and
// in_stall_o is low; in_stall_o stays high until the command has handed its
// last result to the output register. Results leave on the output channel
// one per transfer, with last_o set on the final result of a command.
// Append answers in the dispatch state, as does read for a bad index; a
// good read answers once the RAM read returns. Search and filter first scan
// the N held entries to count matches, then give a no-match result or scan
// again to report the matches; update and delete scan once, then report a
// summary. Each sort compare needs one RAM read and one compare step, as
// the single RAM read port is shared by every pass.
// When the receiver stalls, the result stays in the output register and
// the sequencer waits on the next result it would emit.
// Reset empties the table and sets the price bounds to 100 and 800;
// record contents are not cleared. The user must write registers over the
// APB port only while no command is in progress; the block does not enforce it.
// ----------------------------------------------------------------------------
module record_table_sort_search #(
  parameter int DEPTH = rtss_pkg::DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // command channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  cmd_i,
  input  logic [3:0]  slot_i,
  input  logic [15:0] rec_id_i,
  input  logic [15:0] rec_price_i,
  input  logic [63:0] rec_name_i,
  input  logic [63:0] rec_category_i,
  input  logic [63:0] match_name_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [3:0]  out_slot_o,
  output logic [15:0] out_id_o,
  output logic [15:0] out_price_o,
  output logic [63:0] out_name_o,
  output logic [63:0] out_category_o,
  output logic [4:0]  affected_o,
  output logic        last_o,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import rtss_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int RW = $bits(rec_t);

  // ---------------- configuration registers ----------------
  logic [15:0] price_low_q, price_high_q;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      price_low_q  <= PRICE_LOW_RST;
      price_high_q <= PRICE_HIGH_RST;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == REG_PRICE_LOW) begin
        price_low_q <= pwdata[15:0];
      end else begin
        price_high_q <= pwdata[15:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_PRICE_HIGH) ? {16'd0, price_high_q}
                                                : {16'd0, price_low_q};

  // ---------------- sequencer state ----------------
  state_e        state_q, state_d;
  logic [2:0]    cmd_q;
  logic [3:0]    slot_q;
  rec_t          inrec_q;
  logic [63:0]   mname_q;
  rec_t          reci_q, reci_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] jdx_q, jdx_d;
  logic [CW-1:0] wp_q, wp_d;
  logic [CW-1:0] total_q, total_d;
  logic [3:0]    run_q, run_d;

  // RAM port
  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  rec_t          wdata, rdata;

  rtss_ram #(
    .WIDTH (RW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // ---------------- output register ----------------
  result_t out_q;
  logic    out_valid_q;
  logic    out_free;
  logic    emit;
  result_t res;

  assign out_free = !out_valid_q || !out_stall_i;

  logic accept;
  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  logic scan_match;
  logic idx_in;
  logic run_fin;

  always_comb begin
    unique case (cmd_q)
      CMD_SEARCH: scan_match = (rdata.id == inrec_q.id);
      CMD_FILTER: scan_match = (rdata.price >= price_low_q) &&
                               (rdata.price <= price_high_q);
      default:    scan_match = 1'b0;
    endcase
  end

  assign idx_in  = (idx_q < cnt_q);
  assign run_fin = (run_q == 4'(MAX_RUN - 1)) || ((32'(run_q) + 32'd1) == 32'(total_q));

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    jdx_d   = jdx_q;
    wp_d    = wp_q;
    total_d = total_q;
    run_d   = run_q;
    reci_d  = reci_q;
    we      = 1'b0;
    waddr   = AW'(idx_q);
    wdata   = inrec_q;
    re      = 1'b0;
    raddr   = AW'(idx_q);
    emit    = 1'b0;
    res     = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        idx_d   = '0;
        wp_d    = '0;
        total_d = '0;
        run_d   = '0;
        unique case (cmd_q)
          CMD_APPEND: begin
            if (out_free) begin
              emit = 1'b1;
              res.last = 1'b1;
              if (cnt_q == CW'(DEPTH)) begin
                res.status   = STAT_FULL;
                res.affected = 5'(cnt_q);
              end else begin
                we           = 1'b1;
                waddr        = AW'(cnt_q);
                res.status   = STAT_OK;
                res.slot     = 4'(cnt_q);
                res.rec      = inrec_q;
                res.affected = 5'(cnt_q + CW'(1));
                cnt_d        = cnt_q + CW'(1);
              end
              state_d = S_IDLE;
            end
          end
          CMD_READ: begin
            if (32'(slot_q) >= 32'(cnt_q)) begin
              if (out_free) begin
                emit         = 1'b1;
                res.status   = STAT_BADIDX;
                res.affected = 5'(cnt_q);
                res.last     = 1'b1;
                state_d      = S_IDLE;
              end
            end else begin
              re      = 1'b1;
              raddr   = AW'(slot_q);
              state_d = S_READ_WAIT;
            end
          end
          CMD_SEARCH, CMD_FILTER, CMD_UPDATE, CMD_DELETE: state_d = S_SCAN_RD;
          CMD_SORT: state_d = S_SORT_RDI;
          default:  state_d = S_IDLE;
        endcase
      end

      S_READ_WAIT: begin
        if (out_free) begin
          emit         = 1'b1;
          res.status   = STAT_OK;
          res.slot     = slot_q;
          res.rec      = rdata;
          res.affected = 5'(cnt_q);
          res.last     = 1'b1;
          state_d      = S_IDLE;
        end
      end

      S_SCAN_RD: begin
        if (idx_in) begin
          re      = 1'b1;
          state_d = S_SCAN_CHK;
        end else begin
          idx_d = '0;
          priority case (cmd_q)
            CMD_SEARCH, CMD_FILTER: begin
              state_d = (total_q == '0) ? S_NOMATCH : S_EMIT_RD;
            end
            CMD_DELETE: begin
              cnt_d   = wp_q;
              state_d = S_SUMMARY;
            end
            default: state_d = S_SUMMARY;
          endcase
        end
      end

      S_SCAN_CHK: begin
        idx_d   = idx_q + CW'(1);
        state_d = S_SCAN_RD;
        priority case (cmd_q)
          CMD_UPDATE: begin
            if (rdata.name == mname_q) begin
              we      = 1'b1;
              total_d = total_q + CW'(1);
            end
          end
          CMD_DELETE: begin
            if (rdata.category == inrec_q.category) begin
              total_d = total_q + CW'(1);
            end else begin
              // Kept entries slide down to the write pointer, in order.
              we    = 1'b1;
              waddr = AW'(wp_q);
              wdata = rdata;
              wp_d  = wp_q + CW'(1);
            end
          end
          default: begin
            if (scan_match) begin
              total_d = total_q + CW'(1);
            end
          end
        endcase
      end

      S_EMIT_RD: begin
        if (idx_in) begin
          re      = 1'b1;
          state_d = S_EMIT_CHK;
        end else begin
          state_d = S_IDLE;
        end
      end

      S_EMIT_CHK: begin
        if (!scan_match) begin
          idx_d   = idx_q + CW'(1);
          state_d = S_EMIT_RD;
        end else if (out_free) begin
          emit         = 1'b1;
          res.status   = STAT_OK;
          res.slot     = 4'(idx_q);
          res.rec      = rdata;
          res.affected = 5'(total_q);
          res.last     = run_fin;
          run_d        = run_q + 4'd1;
          idx_d        = idx_q + CW'(1);
          state_d      = run_fin ? S_IDLE : S_EMIT_RD;
        end
      end

      S_NOMATCH: begin
        if (out_free) begin
          emit       = 1'b1;
          res.status = STAT_NOMATCH;
          res.last   = 1'b1;
          state_d    = S_IDLE;
        end
      end

      // Exchange sort: entry i lives in reci_q while j sweeps above it.
      S_SORT_RDI: begin
        if (idx_in) begin
          re      = 1'b1;
          state_d = S_SORT_LDI;
        end else begin
          state_d = S_SUMMARY;
        end
      end

      S_SORT_LDI: begin
        reci_d  = rdata;
        jdx_d   = idx_q + CW'(1);
        state_d = S_SORT_RDJ;
      end

      S_SORT_RDJ: begin
        if (jdx_q < cnt_q) begin
          re      = 1'b1;
          raddr   = AW'(jdx_q);
          state_d = S_SORT_CMP;
        end else begin
          we      = 1'b1;
          wdata   = reci_q;
          idx_d   = idx_q + CW'(1);
          state_d = S_SORT_RDI;
        end
      end

      S_SORT_CMP: begin
        if (reci_q.price > rdata.price) begin
          we     = 1'b1;
          waddr  = AW'(jdx_q);
          wdata  = reci_q;
          reci_d = rdata;
        end
        jdx_d   = jdx_q + CW'(1);
        state_d = S_SORT_RDJ;
      end

      S_SUMMARY: begin
        if (out_free) begin
          emit     = 1'b1;
          res.last = 1'b1;
          if (cmd_q == CMD_SORT) begin
            res.status   = STAT_OK;
            res.affected = 5'(cnt_q);
          end else begin
            res.status   = (total_q == '0) ? STAT_NOMATCH : STAT_OK;
            res.affected = 5'(total_q);
          end
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      idx_q       <= '0;
      jdx_q       <= '0;
      wp_q        <= '0;
      total_q     <= '0;
      run_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      jdx_q   <= jdx_d;
      wp_q    <= wp_d;
      total_q <= total_d;
      run_q   <= run_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    reci_q <= reci_d;
    if (emit) begin
      out_q <= res;
    end
    if (accept) begin
      cmd_q             <= cmd_i;
      slot_q            <= slot_i;
      inrec_q.id        <= rec_id_i;
      inrec_q.price     <= rec_price_i;
      inrec_q.name      <= rec_name_i;
      inrec_q.category  <= rec_category_i;
      mname_q           <= match_name_i;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_q.status;
  assign out_slot_o     = out_q.slot;
  assign out_id_o       = out_q.rec.id;
  assign out_price_o    = out_q.rec.price;
  assign out_name_o     = out_q.rec.name;
  assign out_category_o = out_q.rec.category;
  assign affected_o     = out_q.affected;
  assign last_o         = out_q.last;

  // ---------------- assertions ----------------
  a_accept_starts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == S_DISPATCH)
    else $error("accepted command did not start the sequencer");

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) <= DEPTH)
    else $error("entry count exceeds table depth");

  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && out_valid_q) |-> !out_stall_i)
    else $error("result emitted over a stalled result");

  a_emit_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> state_q != S_IDLE)
    else $error("result emitted while idle");

endmodule

// File: hw/rtl/rtss_ram.sv
// ----------------------------------------------------------------------------
// rtss_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module rtss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
